[hw/rtl/bsrf_pkg.sv]
package bsrf_pkg;

    localparam int PTR_W           = 16;
    localparam int BYTE_W          = 8;
    localparam int MAP_W           = 3;
    // The store depth must be a power of two; the pointer is cut to its low bits.
    localparam int FILE_DEPTH_DEF  = 65536;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BYTE_W-1:0] PORT_LOW_DRAM  = 8'hE0;
    localparam logic [BYTE_W-1:0] PORT_HIGH_DRAM = 8'hE1;
    localparam logic [BYTE_W-1:0] PORT_LOW_ROM   = 8'hE2;
    localparam logic [BYTE_W-1:0] PORT_HIGH_IO   = 8'hE3;
    localparam logic [BYTE_W-1:0] PORT_MAP_RESET = 8'hE4;
    localparam logic [BYTE_W-1:0] PORT_CG_ON     = 8'hE5;
    localparam logic [BYTE_W-1:0] PORT_CG_OFF    = 8'hE6;
    localparam logic [BYTE_W-1:0] PORT_DATA      = 8'hEA;
    localparam logic [BYTE_W-1:0] PORT_CTRL      = 8'hEB;

    localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [MAP_W-1:0] MAP_DRAM_DRAM = 3'd0;
    localparam logic [MAP_W-1:0] MAP_DRAM_IO   = 3'd1;
    localparam logic [MAP_W-1:0] MAP_ROM_DRAM  = 3'd3;
    localparam logic [MAP_W-1:0] MAP_ROM_IO    = 3'd4;

    typedef struct packed {
        logic              file_rd;
        logic              file_wr;
        logic [PTR_W-1:0]  ptr;
        logic [BYTE_W-1:0] data;
        logic [MAP_W-1:0]  page_map;
        logic              char_gen;
    } entry_t;

    function automatic logic [MAP_W-1:0] page_map_f(input logic low_dram,
                                                    input logic high_dram,
                                                    input logic char_gen);
        logic high_ram;
        high_ram = high_dram & ~char_gen;
        if (low_dram)
        begin
            page_map_f = high_ram ? MAP_DRAM_DRAM : MAP_DRAM_IO;
        end
        else
        begin
            page_map_f = high_ram ? MAP_ROM_DRAM : MAP_ROM_IO;
        end
    endfunction

endpackage

[hw/rtl/bsrf_front.sv]
module bsrf_front
    import bsrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [PTR_W-1:0]  port_address,
    input  logic [BYTE_W-1:0] write_data,
    output logic              push_valid,
    input  logic              push_ready,
    output entry_t            push_entry
);

    logic             low_dram_reg, low_dram_next;
    logic             high_dram_reg, high_dram_next;
    logic             char_gen_reg, char_gen_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [BYTE_W-1:0] port;
    logic             is_write;
    logic             accept;

    assign port       = port_address[BYTE_W-1:0];
    assign is_write   = (opcode == OP_WRITE);
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid & push_ready;

    always_comb
    begin
        low_dram_next  = low_dram_reg;
        high_dram_next = high_dram_reg;
        char_gen_next  = char_gen_reg;
        ptr_next       = ptr_reg;
        unique case (port)
            PORT_LOW_DRAM:  low_dram_next  = 1'b1;
            PORT_HIGH_DRAM: high_dram_next = 1'b1;
            PORT_LOW_ROM:   low_dram_next  = 1'b0;
            PORT_HIGH_IO:   high_dram_next = 1'b0;
            PORT_MAP_RESET:
            begin
                low_dram_next  = 1'b0;
                high_dram_next = 1'b0;
                char_gen_next  = 1'b0;
            end
            PORT_CG_ON:     char_gen_next  = 1'b1;
            PORT_CG_OFF:    char_gen_next  = 1'b0;
            PORT_DATA:      ptr_next       = ptr_reg + 1'b1;
            PORT_CTRL:
            begin
                if (is_write)
                begin
                    ptr_next = {port_address[PTR_W-1:BYTE_W], write_data};
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        push_entry.file_rd  = (port == PORT_DATA) & ~is_write;
        push_entry.file_wr  = (port == PORT_DATA) & is_write;
        push_entry.ptr      = ptr_reg;
        push_entry.data     = write_data;
        push_entry.page_map = page_map_f(low_dram_next, high_dram_next, char_gen_next);
        push_entry.char_gen = char_gen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_dram_reg  <= 1'b0;
            high_dram_reg <= 1'b0;
            char_gen_reg  <= 1'b0;
            ptr_reg       <= '0;
        end
        else if (accept)
        begin
            low_dram_reg  <= low_dram_next;
            high_dram_reg <= high_dram_next;
            char_gen_reg  <= char_gen_next;
            ptr_reg       <= ptr_next;
        end
    end

endmodule

[hw/rtl/bsrf_queue.sv]
module bsrf_queue
    import bsrf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_idx_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_idx_next = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_idx_reg] <= push_entry;
        end
    end

endmodule

[hw/rtl/bsrf_back.sv]
module bsrf_back
    import bsrf_pkg::*;
#(
    parameter int FILE_DEPTH = FILE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  entry_t            pop_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] read_data,
    output logic [MAP_W-1:0]  page_map,
    output logic              char_gen_enabled
);

    localparam int ADDR_W = $clog2(FILE_DEPTH);

    logic [BYTE_W-1:0] file_mem [FILE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic              out_valid_reg, out_valid_next;
    logic              file_rd_reg;
    logic [MAP_W-1:0]  page_map_reg;
    logic              char_gen_reg;
    logic [ADDR_W-1:0] addr;
    logic              do_pop;

    assign addr      = pop_entry.ptr[ADDR_W-1:0];
    assign pop_ready = ~out_valid_reg | out_ready;
    assign do_pop    = pop_valid & pop_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            file_rd_reg  <= pop_entry.file_rd;
            page_map_reg <= pop_entry.page_map;
            char_gen_reg <= pop_entry.char_gen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && pop_entry.file_wr)
        begin
            file_mem[addr] <= pop_entry.data;
        end
        if (do_pop && pop_entry.file_rd)
        begin
            rdata_reg <= file_mem[addr];
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = file_rd_reg ? rdata_reg : IDLE_BYTE;
    assign page_map         = page_map_reg;
    assign char_gen_enabled = char_gen_reg;

endmodule

[hw/rtl/bank_switch_and_ram_file_port_unit.sv]
// Bank switch and RAM-file I/O port unit.
// Slave stream s_*: one I/O access per word. s_tuser is the access kind
// (0 read, 1 write); s_tdata carries the port address and the write byte.
// Master stream m_*: one result word per access, in order, with the read
// byte, the page map selected after the access and the char-gen flag.
// Ports E0..E6 switch the bank flags on reads and writes alike; EB (write)
// loads the file pointer, EA reads or writes the file store at the pointer
// and advances it.
// Each accepted word is written into the queue and then into the back's
// output register before it shows on m_*. Throughput: one word per cycle
// while m_tready is held high.
// The front decodes and updates the bank flags and the pointer; a short
// queue hands words to the back, which owns the store and the output
// register. A stalled receiver fills the queue, and s_tready drops only
// when it is full. Reset clears the flags, the pointer and all valid
// state; the file store keeps no reset and holds garbage until written.
module bank_switch_and_ram_file_port_unit
    import bsrf_pkg::*;
#(
    parameter int FILE_DEPTH  = FILE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // port_address[15:0], write_data[23:16]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], page_map[10:8], char_gen_enabled[11], zero
);

    logic              push_valid;
    logic              push_ready;
    entry_t            push_entry;
    logic              pop_valid;
    logic              pop_ready;
    entry_t            pop_entry;
    logic [BYTE_W-1:0] read_data;
    logic [MAP_W-1:0]  page_map;
    logic              char_gen_enabled;

    bsrf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .opcode       (s_tuser[0]),
        .port_address (s_tdata[15:0]),
        .write_data   (s_tdata[23:16]),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    bsrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    bsrf_back #(
        .FILE_DEPTH (FILE_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_entry        (pop_entry),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .read_data        (read_data),
        .page_map         (page_map),
        .char_gen_enabled (char_gen_enabled)
    );

    assign m_tdata = {4'b0000, char_gen_enabled, page_map, read_data};

endmodule

[hw/rtl/bsrf_checker.sv]
module bsrf_checker
    import bsrf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

    a_map_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:8] == MAP_DRAM_DRAM || m_tdata[10:8] == MAP_DRAM_IO ||
                      m_tdata[10:8] == MAP_ROM_DRAM || m_tdata[10:8] == MAP_ROM_IO))
    else $error("illegal page map");

    a_cg_map: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> (m_tdata[10:8] == MAP_DRAM_IO ||
                                     m_tdata[10:8] == MAP_ROM_IO))
    else $error("char gen active with high DRAM mapped");

    a_reset_idle: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
    else $error("result word right after reset");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'b0000)
    else $error("result pad bits set");

endmodule

bind bank_switch_and_ram_file_port_unit bsrf_checker u_bsrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/bank_switch_and_ram_file_port_unit_tb.sv]
`timescale 1ns / 1ps

module bank_switch_and_ram_file_port_unit_tb;
    import bsrf_pkg::*;

    typedef struct {
        logic              op;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
        bit                drain;
    } access_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic [MAP_W-1:0]  map;
        logic              cg;
    } reply_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    access_t pend_q[$];
    reply_t  reply_q[$];

    int n_total = 0;
    int n_acc   = 0;
    int n_done  = 0;
    int n_err   = 0;
    int gap_left  = 0;
    int hold_left = 0;
    bit stall_done = 1'b0;
    logic drive_go;

    logic [PTR_W-1:0]  gen_ptr = '0;
    bit                gen_written [0:FILE_DEPTH_DEF-1];

    logic              bank_low  = 1'b0;
    logic              bank_high = 1'b0;
    logic              bank_cg   = 1'b0;
    logic [PTR_W-1:0]  file_ptr  = '0;
    logic [BYTE_W-1:0] file_mem [0:FILE_DEPTH_DEF-1];

    bank_switch_and_ram_file_port_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // port_address[15:0], write_data[23:16]
        .s_tuser  (s_tuser),   // opcode[0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // read_data[7:0], page_map[10:8], char_gen_enabled[11], zero
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Queue an access; steer data-port reads away from bytes never written.
    task automatic add_access(input logic op, input logic [PTR_W-1:0] addr,
                              input logic [BYTE_W-1:0] wd);
        access_t a;
        logic    op_f;
        op_f = op;
        if (addr[7:0] == PORT_DATA)
        begin
            if (op_f == OP_READ && !gen_written[gen_ptr])
            begin
                op_f = OP_WRITE;
            end
            if (op_f == OP_WRITE)
            begin
                gen_written[gen_ptr] = 1'b1;
            end
            gen_ptr = gen_ptr + 1'b1;
        end
        else if (addr[7:0] == PORT_CTRL && op_f == OP_WRITE)
        begin
            gen_ptr = {addr[15:8], wd};
        end
        a.op    = op_f;
        a.addr  = addr;
        a.wdata = wd;
        a.drain = 1'b0;
        pend_q.push_back(a);
    endtask

    task automatic apply_access(input logic op, input logic [PTR_W-1:0] addr,
                                input logic [BYTE_W-1:0] wd);
        reply_t rep;
        logic   high_ram;
        case (addr[7:0])
            PORT_LOW_DRAM:  bank_low  = 1'b1;
            PORT_HIGH_DRAM: bank_high = 1'b1;
            PORT_LOW_ROM:   bank_low  = 1'b0;
            PORT_HIGH_IO:   bank_high = 1'b0;
            PORT_MAP_RESET:
            begin
                bank_low  = 1'b0;
                bank_high = 1'b0;
                bank_cg   = 1'b0;
            end
            PORT_CG_ON:     bank_cg   = 1'b1;
            PORT_CG_OFF:    bank_cg   = 1'b0;
            default:        ;
        endcase
        rep.rd = IDLE_BYTE;
        if (addr[7:0] == PORT_DATA)
        begin
            if (op == OP_WRITE)
            begin
                file_mem[file_ptr] = wd;
            end
            else
            begin
                rep.rd = file_mem[file_ptr];
            end
            file_ptr = file_ptr + 1'b1;
        end
        else if (addr[7:0] == PORT_CTRL && op == OP_WRITE)
        begin
            file_ptr = {addr[15:8], wd};
        end
        high_ram = bank_high & ~bank_cg;
        if (bank_low)
        begin
            rep.map = high_ram ? MAP_DRAM_DRAM : MAP_DRAM_IO;
        end
        else
        begin
            rep.map = high_ram ? MAP_ROM_DRAM : MAP_ROM_IO;
        end
        rep.cg = bank_cg;
        reply_q.push_back(rep);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
            begin
                apply_access(s_tuser[0], s_tdata[15:0], s_tdata[23:16]);
                n_acc++;
                void'(pend_q.pop_front());
                if (n_acc < n_total - 50 && ((n_acc / 40) % 3) != 2
                    && $urandom_range(0, 3) == 0)
                begin
                    gap_left = $urandom_range(1, 9);
                end
            end
            drive_go = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pend_q.size() > 0 && (!pend_q[0].drain || n_done == n_acc))
            begin
                drive_go = 1'b1;
            end
            s_tvalid <= drive_go;
            if (drive_go)
            begin
                s_tdata <= {pend_q[0].wdata, pend_q[0].addr};
                s_tuser <= pend_q[0].op;
            end
        end
    end

    // receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (!stall_done && n_done >= 100)
            begin
                stall_done = 1'b1;
                hold_left  = 80;
            end
            else if (hold_left == 0 && n_done < n_total - 50 && ((n_done / 50) % 3) != 1
                     && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(1, 9);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_done <= n_done + 1;
            if (reply_q.size() == 0)
            begin
                if (n_err < 10)
                begin
                    $display("unexpected word: tdata=%h", m_tdata);
                end
                n_err++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (m_tdata[7:0] !== want.rd || m_tdata[10:8] !== want.map
                    || m_tdata[11] !== want.cg || m_tdata[15:12] !== 4'h0)
                begin
                    if (n_err < 10)
                    begin
                        $display("mismatch word %0d: rd exp %h got %h, map exp %0d got %0d, cg exp %b got %b, pad got %h",
                                 n_done, want.rd, m_tdata[7:0], want.map, m_tdata[10:8],
                                 want.cg, m_tdata[11], m_tdata[15:12]);
                    end
                    n_err++;
                end
            end
        end
    end

    initial
    begin
        logic [PTR_W-1:0] base;
        int               len;
        int               n_dir;

        add_access(OP_WRITE, 16'h00E0, 8'h00);
        add_access(OP_READ,  16'hFFE1, 8'hFF);
        add_access(OP_WRITE, 16'h55E5, 8'hAA);
        add_access(OP_READ,  16'hAAE6, 8'h55);
        add_access(OP_WRITE, 16'h00E2, 8'hFF);
        add_access(OP_READ,  16'hFFE3, 8'h00);
        add_access(OP_READ,  16'h00E0, 8'h00);
        add_access(OP_WRITE, 16'h00E1, 8'h00);
        add_access(OP_WRITE, 16'h00E5, 8'h00);
        add_access(OP_READ,  16'h12E4, 8'h00);
        // pointer wrap at the top of the store
        add_access(OP_WRITE, 16'hFFEB, 8'hFF);
        add_access(OP_WRITE, 16'h00EA, 8'h00);
        add_access(OP_WRITE, 16'hFFEA, 8'hFF);
        // control port read leaves the pointer alone
        add_access(OP_READ,  16'h34EB, 8'h00);
        add_access(OP_WRITE, 16'h80EA, 8'h5A);
        add_access(OP_WRITE, 16'hFFEB, 8'hFF);
        add_access(OP_READ,  16'h00EA, 8'h00);
        add_access(OP_READ,  16'hFFEA, 8'hFF);
        add_access(OP_READ,  16'h7FEA, 8'h00);
        add_access(OP_READ,  16'hFFFF, 8'h00);
        add_access(OP_WRITE, 16'h0000, 8'hFF);
        add_access(OP_READ,  16'h00E7, 8'h00);
        add_access(OP_WRITE, 16'hFFE9, 8'h12);
        n_dir = pend_q.size();

        while (pend_q.size() < 550)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    base = ($urandom_range(0, 3) == 0) ? 16'(16'hFFFC + $urandom_range(0, 3))
                                                        : 16'($urandom);
                    len = $urandom_range(1, 8);
                    add_access(OP_WRITE, {base[15:8], PORT_CTRL}, base[7:0]);
                    repeat (len) add_access(OP_WRITE, {8'($urandom), PORT_DATA}, 8'($urandom));
                    add_access(OP_WRITE, {base[15:8], PORT_CTRL}, base[7:0]);
                    repeat (len) add_access(OP_READ, {8'($urandom), PORT_DATA}, 8'($urandom));
                end
                4, 5, 6:
                begin
                    add_access(1'($urandom),
                               {8'($urandom), 8'(PORT_LOW_DRAM + $urandom_range(0, 6))},
                               8'($urandom));
                end
                7: add_access(1'($urandom), {8'($urandom), PORT_DATA}, 8'($urandom));
                8: add_access(1'($urandom), {8'($urandom), PORT_CTRL}, 8'($urandom));
                default: add_access(1'($urandom), 16'($urandom), 8'($urandom));
            endcase
        end
        pend_q[n_dir].drain = 1'b1;
        pend_q[300].drain   = 1'b1;
        n_total = pend_q.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_acc == n_total);
        wait (n_done == n_acc);
        repeat (10) @(posedge clk);
        if (n_err == 0 && reply_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
